### rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF = 256;
    localparam int ALIGN_BYTES    = 4;
    localparam int DIV_W          = 17;
    localparam int CFG_IDX_W      = 1;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_LARGE  = 3'd1,
        ST_NO_MEMORY  = 3'd2,
        ST_BAD_CONFIG = 3'd3,
        ST_NOT_READY  = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POOL_BYTES  = 1'b0,
        REG_BLOCK_BYTES = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic eff_cap;
        logic cnt_cap;
        logic sweep_clr;
        logic sweep_wr;
        logic fin_exec;
        logic fin_init_ok;
        logic fin_init_bad;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic eff_bad;
        logic cnt_bad;
        logic sweep_last;
        logic out_free;
    } stat_t;

endpackage

### rtl/core/fbpa_div.sv
// ----------------------------------------------------------------------------
// fbpa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbpa_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [fbpa_pkg::DIV_W-1:0] dividend,
    input  logic [fbpa_pkg::DIV_W-1:0] divisor,
    output logic                      done,
    output logic [fbpa_pkg::DIV_W-1:0] quotient
);
    import fbpa_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;

    logic [DIV_W:0]   shifted;
    logic [DIV_W+1:0] diff;
    logic             ge;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W-1:0] quo_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DIV_W-1]};
        diff     = {1'b0, shifted} - {2'b00, dvs_reg};
        ge       = !diff[DIV_W+1];
        rem_next = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(DIV_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencer: decodes the opcode and steps the init sequence.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_opcode,
    input  fbpa_pkg::stat_t     stat,
    output fbpa_pkg::cmd_t      cmd
);
    import fbpa_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_EXEC      = 9'b000000010,
        S_RND_WAIT  = 9'b000000100,
        S_EFF_CHK   = 9'b000001000,
        S_CNT_WAIT  = 9'b000010000,
        S_CNT_CHK   = 9'b000100000,
        S_SWEEP     = 9'b001000000,
        S_REPLY_OK  = 9'b010000000,
        S_REPLY_BAD = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (op_t'(s_opcode) == OP_INIT) begin
                        state_next = S_RND_WAIT;
                    end else begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (stat.out_free) begin
                    cmd.fin_exec = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_RND_WAIT: begin
                cmd.eff_cap = 1'b1;
                state_next  = S_EFF_CHK;
            end
            S_EFF_CHK: begin
                if (stat.eff_bad) begin
                    state_next = S_REPLY_BAD;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_CNT_WAIT;
                end
            end
            S_CNT_WAIT: begin
                if (stat.div_done) begin
                    cmd.cnt_cap = 1'b1;
                    state_next  = S_CNT_CHK;
                end
            end
            S_CNT_CHK: begin
                if (stat.cnt_bad) begin
                    state_next = S_REPLY_BAD;
                end else begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = S_SWEEP;
                end
            end
            S_SWEEP: begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_REPLY_OK;
                end
            end
            S_REPLY_OK: begin
                if (stat.out_free) begin
                    cmd.fin_init_ok = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_REPLY_BAD: begin
                if (stat.out_free) begin
                    cmd.fin_init_bad = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/fbpa_dp.sv
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath: config registers, free list link memory, list head, byte count,
// init divider and the result register.
// ----------------------------------------------------------------------------
module fbpa_dp #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic [1:0]                    s_opcode,
    input  logic [15:0]                   s_request_bytes,
    input  logic [7:0]                    s_block_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [7:0]                    m_granted_index,
    output logic [15:0]                   m_free_bytes,
    input  fbpa_pkg::cmd_t                cmd,
    output fbpa_pkg::stat_t               stat
);
    import fbpa_pkg::*;

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
    localparam int IXE_W  = (IDX_W > 8) ? IDX_W : 8;

    // config
    logic [15:0] pool_reg;
    logic [15:0] block_reg;

    // latched request
    op_t         op_reg;
    logic [15:0] req_reg;
    logic [7:0]  index_reg;

    // allocator state
    logic [LINK_W-1:0] head_reg, head_next;
    logic [15:0]       free_reg, free_next;
    logic [15:0]       eff_reg, eff_next;
    logic              ready_reg, ready_next;

    // init scratch
    logic [DIV_W-1:0] eff_tmp_reg;
    logic [DIV_W-1:0] cnt_reg;
    logic [IDX_W-1:0] sweep_reg;

    // link memory
    logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
    logic [LINK_W-1:0] rdata_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [LINK_W-1:0] mem_wdata;

    // result
    logic        m_valid_reg, m_valid_next;
    status_t     status_reg, status_next;
    logic [7:0]  grant_reg, grant_next;
    logic [15:0] out_free_reg, out_free_next;

    // divider
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;

    logic [LINK_W-1:0] null_link;
    logic [DIV_W-1:0]  rnd_sum;
    logic [16:0]       free_sum;
    logic [15:0]       free_add;
    logic [15:0]       free_sub;
    logic [IXE_W-1:0]  idx_ext;
    logic              idx_in_range;
    logic              head_null;
    logic              sweep_last;

    status_t     ex_status;
    logic [7:0]  ex_grant;
    logic [15:0] ex_free;
    logic        ex_pop;
    logic        ex_push;

    always_comb begin
        null_link    = LINK_W'(MAX_BLOCKS);
        rnd_sum      = {1'b0, block_reg} + DIV_W'(ALIGN_BYTES - 1);
        free_sum     = {1'b0, free_reg} + {1'b0, eff_reg};
        free_add     = free_sum[16] ? 16'hFFFF : free_sum[15:0];
        free_sub     = (free_reg >= eff_reg) ? (free_reg - eff_reg) : 16'd0;
        idx_ext      = IXE_W'(index_reg);
        idx_in_range = ({24'd0, index_reg} < 32'(MAX_BLOCKS));
        head_null    = (head_reg >= null_link);
        sweep_last   = (DIV_W'(sweep_reg) == (cnt_reg - DIV_W'(1)));
        div_dividend = {1'b0, pool_reg};
        div_divisor  = eff_tmp_reg;
    end

    fbpa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo)
    );

    always_comb begin
        stat.div_done   = div_done;
        stat.eff_bad    = (eff_tmp_reg == '0) || (eff_tmp_reg > {1'b0, pool_reg});
        stat.cnt_bad    = (cnt_reg > DIV_W'(MAX_BLOCKS));
        stat.sweep_last = sweep_last;
        stat.out_free   = !m_valid_reg || m_ready;
    end

    // alloc / free / nop outcome
    always_comb begin
        ex_status = ST_OK;
        ex_grant  = 8'd0;
        ex_free   = free_reg;
        ex_pop    = 1'b0;
        ex_push   = 1'b0;
        case (op_reg)
            OP_ALLOC: begin
                if (!ready_reg) begin
                    ex_status = ST_NOT_READY;
                end else if (req_reg > eff_reg) begin
                    ex_status = ST_TOO_LARGE;
                end else if (head_null) begin
                    ex_status = ST_NO_MEMORY;
                end else begin
                    ex_pop   = 1'b1;
                    ex_grant = 8'(head_reg);
                    ex_free  = free_sub;
                end
            end
            OP_FREE: begin
                if (!ready_reg) begin
                    ex_status = ST_NOT_READY;
                end else if (idx_in_range) begin
                    ex_push = 1'b1;
                    ex_free = free_add;
                end
            end
            default: begin
                ex_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        head_next     = head_reg;
        free_next     = free_reg;
        eff_next      = eff_reg;
        ready_next    = ready_reg;
        status_next   = status_reg;
        grant_next    = grant_reg;
        out_free_next = out_free_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        if (cmd.fin_exec) begin
            if (ex_pop) begin
                head_next = rdata_reg;
            end else if (ex_push) begin
                head_next = LINK_W'(index_reg);
            end
            free_next     = ex_free;
            status_next   = ex_status;
            grant_next    = ex_grant;
            out_free_next = ex_free;
            m_valid_next  = 1'b1;
        end else if (cmd.fin_init_ok) begin
            head_next     = '0;
            free_next     = pool_reg;
            eff_next      = eff_tmp_reg[15:0];
            ready_next    = 1'b1;
            status_next   = ST_OK;
            grant_next    = 8'd0;
            out_free_next = pool_reg;
            m_valid_next  = 1'b1;
        end else if (cmd.fin_init_bad) begin
            status_next   = ST_BAD_CONFIG;
            grant_next    = 8'd0;
            out_free_next = free_reg;
            m_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg    <= '0;
            block_reg   <= '0;
            head_reg    <= LINK_W'(MAX_BLOCKS);
            free_reg    <= '0;
            eff_reg     <= '0;
            ready_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_reg_t'(cfg_index))
                    REG_POOL_BYTES:  pool_reg  <= cfg_data;
                    REG_BLOCK_BYTES: block_reg <= cfg_data;
                    default: begin
                        pool_reg <= pool_reg;
                    end
                endcase
            end
            head_reg    <= head_next;
            free_reg    <= free_next;
            eff_reg     <= eff_next;
            ready_reg   <= ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= op_t'(s_opcode);
            req_reg   <= s_request_bytes;
            index_reg <= s_block_index;
        end
        if (cmd.eff_cap) begin
            eff_tmp_reg <= rnd_sum & ~DIV_W'(ALIGN_BYTES - 1);
        end
        if (cmd.cnt_cap) begin
            cnt_reg <= div_quo;
        end
        if (cmd.sweep_clr) begin
            sweep_reg <= '0;
        end else if (cmd.sweep_wr) begin
            sweep_reg <= sweep_reg + IDX_W'(1);
        end
        status_reg   <= status_next;
        grant_reg    <= grant_next;
        out_free_reg <= out_free_next;
    end

    // link memory: one write port, one registered read port at the head
    always_comb begin
        mem_we    = cmd.sweep_wr || (cmd.fin_exec && ex_push);
        mem_waddr = cmd.sweep_wr ? sweep_reg : idx_ext[IDX_W-1:0];
        if (cmd.sweep_wr) begin
            mem_wdata = sweep_last ? null_link : (LINK_W'(sweep_reg) + LINK_W'(1));
        end else begin
            mem_wdata = head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= link_mem[head_reg[IDX_W-1:0]];
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_granted_index = grant_reg;
    assign m_free_bytes    = out_free_reg;

endmodule

### rtl/core/fixed_block_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Fixed-size block pool allocator with a linked free list of block indices.
// ----------------------------------------------------------------------------
// Alloc, free and no-op: request latched on accept, result registered in the
// execute state once the output is free; no new request is taken before
// that. The link memory read port is read at the list head each cycle.
// Init: rounding and checks, one 17-step divider pass for the block count, then a
// link sweep (a rejected block size skips the divider). Synchronous active-low
// reset clears control, list head, counts, config; link memory is not cleared.
module fixed_block_pool_allocator_core #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_opcode,
    input  logic [15:0]                   s_request_bytes,
    input  logic [7:0]                    s_block_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [7:0]                    m_granted_index,
    output logic [15:0]                   m_free_bytes
);
    import fbpa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    fbpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .stat     (stat),
        .cmd      (cmd)
    );

    fbpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_opcode        (s_opcode),
        .s_request_bytes (s_request_bytes),
        .s_block_index   (s_block_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_index (m_granted_index),
        .m_free_bytes    (m_free_bytes),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

### tb/tb_fixed_block_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator_core
// Self-checking bench for the fixed block pool allocator core. A short table
// of directed requests covers the edges of the configuration and of the
// request fields, and the rejected-init, not-initialized, too-large,
// no-memory, double-free and saturation cases. Random phases follow, each
// with a new pool setup: mostly init, then alloc/free traffic that returns
// granted blocks, mixed with stray frees, re-inits and no-ops. Every result
// is compared with the table's value or an in-bench free-list predictor.
// Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import fbpa_pkg::*;

    localparam int BLOCKS = MAX_BLOCKS_DEF;
    localparam logic [8:0] LIST_END = 9'(BLOCKS);
    localparam int ITEM_TARGET = 2000;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        status_t     status;
        logic [7:0]  grant;
        logic [15:0] free_bytes;
    } pool_result_t;

    typedef struct {
        bit           is_cfg;
        cfg_reg_t     cfg_sel;
        logic [15:0]  cfg_value;
        op_t          op;
        logic [15:0]  req;
        logic [7:0]   idx;
        bit           typed;
        pool_result_t res;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_opcode = '0;
    logic [15:0]          s_request_bytes = '0;
    logic [7:0]           s_block_index = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [2:0]           m_status;
    logic [7:0]           m_granted_index;
    logic [15:0]          m_free_bytes;

    fixed_block_pool_allocator_core #(
        .MAX_BLOCKS(BLOCKS)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_request_bytes (s_request_bytes),
        .s_block_index   (s_block_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_index (m_granted_index),
        .m_free_bytes    (m_free_bytes)
    );

    // free-list predictor state
    logic [8:0]   free_link [BLOCKS];
    logic [8:0]   free_head;
    logic [15:0]  free_byte_count;
    int unsigned  block_size_eff;
    bit           pool_initialized;
    logic [15:0]  cfg_pool_bytes;
    logic [15:0]  cfg_block_bytes;

    pool_result_t expected_results [$];
    logic [7:0]   held_blocks [$];
    int unsigned  sent_cnt = 0;
    int unsigned  done_cnt = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  rx_hold = 0;
    bit           tx_quiet = 1'b0;
    bit           rx_quiet = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic pool_result_t compute_pool_result(op_t op, logic [15:0] req,
                                                         logic [7:0] idx);
        pool_result_t r;
        int unsigned  rounded;
        int unsigned  blocks;
        int unsigned  sum;
        int unsigned  i;
        r.status = ST_OK;
        r.grant  = '0;
        case (op)
            OP_INIT: begin
                rounded = ((cfg_block_bytes + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
                blocks  = (rounded == 0) ? 0 : cfg_pool_bytes / rounded;
                if (rounded == 0 || rounded > cfg_pool_bytes || blocks > BLOCKS) begin
                    r.status = ST_BAD_CONFIG;
                end else begin
                    for (i = 0; i + 1 < blocks; i++)
                        free_link[i] = 9'(i + 1);
                    free_link[blocks - 1] = LIST_END;
                    free_head        = '0;
                    free_byte_count  = cfg_pool_bytes;
                    block_size_eff   = rounded;
                    pool_initialized = 1'b1;
                end
            end
            OP_ALLOC: begin
                if (!pool_initialized) begin
                    r.status = ST_NOT_READY;
                end else if (req > block_size_eff) begin
                    r.status = ST_TOO_LARGE;
                end else if (free_head >= LIST_END) begin
                    r.status = ST_NO_MEMORY;
                end else begin
                    r.grant   = free_head[7:0];
                    free_head = free_link[free_head];
                    free_byte_count = (free_byte_count >= block_size_eff) ?
                                      16'(free_byte_count - block_size_eff) : 16'd0;
                end
            end
            OP_FREE: begin
                if (!pool_initialized) begin
                    r.status = ST_NOT_READY;
                end else if (idx < BLOCKS) begin
                    free_link[idx]  = free_head;
                    free_head       = {1'b0, idx};
                    sum             = free_byte_count + block_size_eff;
                    free_byte_count = (sum > 32'hFFFF) ? 16'hFFFF : 16'(sum);
                end
            end
            default: begin
            end
        endcase
        r.free_bytes = free_byte_count;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(cfg_reg_t sel, logic [15:0] value);
        stim_row_t row;
        row.is_cfg    = 1'b1;
        row.cfg_sel   = sel;
        row.cfg_value = value;
        row.op        = OP_NOP;
        row.req       = '0;
        row.idx       = '0;
        row.typed     = 1'b0;
        row.res       = '0;
        return row;
    endfunction

    function automatic stim_row_t item_row(op_t op, logic [15:0] req, logic [7:0] idx,
                                           bit typed, status_t st, logic [7:0] grant,
                                           logic [15:0] fb);
        stim_row_t row;
        row.is_cfg    = 1'b0;
        row.cfg_sel   = REG_POOL_BYTES;
        row.cfg_value = '0;
        row.op        = op;
        row.req       = req;
        row.idx       = idx;
        row.typed     = typed;
        row.res       = '{st, grant, fb};
        return row;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on result %0d: %s got %0d expected %0d",
                 $realtime, done_cnt, what, got, want);
        mismatch_count++;
    endtask

    // lowers the request valid and waits until every issued request has answered
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (done_cnt < sent_cnt) @(posedge aclk);
    endtask

    task automatic write_config(cfg_reg_t sel, logic [15:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (sel == REG_POOL_BYTES)
            cfg_pool_bytes = value;
        else
            cfg_block_bytes = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(op_t op, logic [15:0] req, logic [7:0] idx, bit typed,
                                pool_result_t typed_res);
        int unsigned  gap;
        pool_result_t res;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_request_bytes <= req;
        s_block_index   <= idx;
        do @(posedge aclk); while (!s_ready);
        res = compute_pool_result(op, req, idx);
        expected_results.push_back(typed ? typed_res : res);
        sent_cnt++;
        if (op == OP_ALLOC && res.status == ST_OK)
            held_blocks.push_back(res.grant);
        if (op == OP_INIT && res.status == ST_OK)
            held_blocks.delete();
    endtask

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else if (rx_quiet || $urandom_range(0, 99) < 75) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            rx_hold = pick_gap();
        end
    end

    always @(posedge aclk) begin : result_check
        pool_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, status", m_status, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_granted_index !== want.grant)
                    report_mismatch("granted_index", m_granted_index, want.grant);
                if (m_free_bytes !== want.free_bytes)
                    report_mismatch("free_bytes", m_free_bytes, want.free_bytes);
            end
            done_cnt++;
        end
        if ((s_valid && s_ready) || (cfg_valid && cfg_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        stim_row_t   directed_rows [$];
        int unsigned random_items;
        int unsigned mode;
        int unsigned items;
        int unsigned r;
        int unsigned k;
        int unsigned blk;
        int unsigned eff;
        int unsigned pool;
        logic [15:0] req;
        logic [7:0]  idx;
        op_t         op;

        free_head        = LIST_END;
        free_byte_count  = '0;
        block_size_eff   = 0;
        pool_initialized = 1'b0;
        cfg_pool_bytes   = '0;
        cfg_block_bytes  = '0;
        random_items     = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // before any init, then rejected inits
        directed_rows.push_back(item_row(OP_ALLOC, 16'hFFFF, 8'h00, 1, ST_NOT_READY, 0, 0));
        directed_rows.push_back(item_row(OP_FREE, 16'h0000, 8'hFF, 1, ST_NOT_READY, 0, 0));
        directed_rows.push_back(item_row(OP_NOP, 16'h5A5A, 8'hA5, 1, ST_OK, 0, 0));
        directed_rows.push_back(item_row(OP_INIT, 16'h0000, 8'h00, 1, ST_BAD_CONFIG, 0, 0));
        directed_rows.push_back(cfg_row(REG_POOL_BYTES, 16'hFFFF));
        directed_rows.push_back(cfg_row(REG_BLOCK_BYTES, 16'hFFFF));
        directed_rows.push_back(item_row(OP_INIT, 16'h0000, 8'h00, 1, ST_BAD_CONFIG, 0, 0));
        directed_rows.push_back(cfg_row(REG_BLOCK_BYTES, 16'd1));
        directed_rows.push_back(item_row(OP_INIT, 16'h0000, 8'h00, 1, ST_BAD_CONFIG, 0, 0));
        directed_rows.push_back(cfg_row(REG_POOL_BYTES, 16'd1028));
        directed_rows.push_back(item_row(OP_INIT, 16'h0000, 8'h00, 1, ST_BAD_CONFIG, 0, 0));
        // full 256-block pool of 4-byte blocks
        directed_rows.push_back(cfg_row(REG_POOL_BYTES, 16'd1024));
        directed_rows.push_back(item_row(OP_INIT, 16'h0000, 8'h00, 1, ST_OK, 0, 1024));
        directed_rows.push_back(item_row(OP_ALLOC, 16'd4, 8'h00, 1, ST_OK, 0, 1020));
        directed_rows.push_back(item_row(OP_ALLOC, 16'd5, 8'h00, 1, ST_TOO_LARGE, 0, 1020));
        directed_rows.push_back(item_row(OP_ALLOC, 16'hFFFF, 8'h00, 1, ST_TOO_LARGE, 0, 1020));
        directed_rows.push_back(item_row(OP_ALLOC, 16'd0, 8'h00, 1, ST_OK, 1, 1016));
        directed_rows.push_back(item_row(OP_FREE, 16'hFFFF, 8'h00, 1, ST_OK, 0, 1020));
        directed_rows.push_back(item_row(OP_FREE, 16'h0000, 8'h00, 0, ST_OK, 0, 0));
        directed_rows.push_back(item_row(OP_ALLOC, 16'd3, 8'hFF, 0, ST_OK, 0, 0));
        directed_rows.push_back(item_row(OP_ALLOC, 16'd2, 8'hFF, 0, ST_OK, 0, 0));
        // single huge block: byte count saturates both ways
        directed_rows.push_back(cfg_row(REG_POOL_BYTES, 16'hFFFF));
        directed_rows.push_back(cfg_row(REG_BLOCK_BYTES, 16'hFFFC));
        directed_rows.push_back(item_row(OP_INIT, 16'h0000, 8'h00, 1, ST_OK, 0, 16'hFFFF));
        directed_rows.push_back(item_row(OP_ALLOC, 16'hFFFC, 8'h00, 1, ST_OK, 0, 3));
        directed_rows.push_back(item_row(OP_ALLOC, 16'd0, 8'h00, 1, ST_NO_MEMORY, 0, 3));
        directed_rows.push_back(item_row(OP_FREE, 16'h0000, 8'hFF, 1, ST_OK, 0, 16'hFFFF));
        directed_rows.push_back(item_row(OP_FREE, 16'h0000, 8'h07, 1, ST_OK, 0, 16'hFFFF));
        directed_rows.push_back(item_row(OP_ALLOC, 16'd1, 8'h00, 0, ST_OK, 0, 0));
        directed_rows.push_back(item_row(OP_ALLOC, 16'd1, 8'h00, 0, ST_OK, 0, 0));
        directed_rows.push_back(item_row(OP_ALLOC, 16'd1, 8'h00, 0, ST_OK, 0, 0));
        directed_rows.push_back(item_row(OP_NOP, 16'h0000, 8'h00, 0, ST_OK, 0, 0));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg)
                write_config(directed_rows[i].cfg_sel, directed_rows[i].cfg_value);
            else
                send_request(directed_rows[i].op, directed_rows[i].req, directed_rows[i].idx,
                             directed_rows[i].typed, directed_rows[i].res);
        end

        while (random_items < ITEM_TARGET) begin
            mode = $urandom_range(0, 9);
            case (mode)
                0, 1, 2, 3, 4: begin
                    blk  = $urandom_range(1, 64);
                    eff  = ((blk + 3) / 4) * 4;
                    pool = eff * $urandom_range(1, 24) + $urandom_range(0, eff - 1);
                end
                5: begin
                    blk  = $urandom_range(1, 252);
                    eff  = ((blk + 3) / 4) * 4;
                    pool = eff * BLOCKS + $urandom_range(0, eff - 1);
                end
                6: begin
                    blk  = $urandom_range(16384, 65532);
                    pool = 65535;
                end
                7: begin
                    blk  = $urandom_range(0, 65535);
                    pool = $urandom_range(0, 65535);
                end
                8: begin
                    pool = $urandom_range(0, 1) ? 65535 : 0;
                    k    = $urandom_range(0, 3);
                    blk  = (k == 0) ? 0 : (k == 1) ? 1 : (k == 2) ? 65532 : 65535;
                end
                default: begin
                    blk  = $urandom_range(1, 64);
                    eff  = ((blk + 3) / 4) * 4;
                    pool = eff * $urandom_range(257, 300);
                end
            endcase
            write_config(REG_POOL_BYTES, 16'(pool));
            write_config(REG_BLOCK_BYTES, 16'(blk));
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet <= ($urandom_range(0, 4) == 0);

            if ($urandom_range(0, 19) != 0) begin
                send_request(OP_INIT, 16'($urandom), 8'($urandom), 1'b0, '0);
                random_items++;
            end

            items = $urandom_range(40, 120);
            repeat (items) begin
                if ($urandom_range(0, 32) == 0)
                    drain_results();
                r   = $urandom_range(0, 99);
                req = 16'($urandom);
                idx = 8'($urandom);
                if (r < 45) begin
                    op = OP_ALLOC;
                    k  = $urandom_range(0, 9);
                    if (k < 8)
                        req = 16'($urandom_range(0, block_size_eff));
                    else if (k == 8 && block_size_eff < 65535)
                        req = 16'($urandom_range(block_size_eff + 1, 65535));
                end else if (r < 85) begin
                    op = OP_FREE;
                    if (held_blocks.size() > 0 && $urandom_range(0, 6) != 0) begin
                        k   = $urandom_range(0, held_blocks.size() - 1);
                        idx = held_blocks[k];
                        held_blocks.delete(k);
                    end
                end else if (r < 93) begin
                    op = OP_NOP;
                end else begin
                    op = OP_INIT;
                end
                send_request(op, req, idx, 1'b0, '0);
                random_items++;
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
